### src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the discrete event queue
// Request and result codes and the decoded command passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int unsigned DefQueueDepth = 64;
  localparam int unsigned DefNumObjects = 16;
  localparam int unsigned DefTimeBits   = 32;

  localparam int unsigned DelayW = 31;
  localparam int unsigned ObjW   = 4;
  localparam int unsigned TypeW  = 8;
  localparam int unsigned CountW = 6;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned SeqW   = 16;

  localparam logic [CountW-1:0] MaxDispatch = 6'd63;

  typedef enum logic [1:0] {
    REQ_SCHEDULE  = 2'd0,
    REQ_ADV_COUNT = 2'd1,
    REQ_ADV_TIME  = 2'd2,
    REQ_SET_BP    = 2'd3
  } deq_req_e;

  typedef enum logic [2:0] {
    KIND_DISPATCHED = 3'd0,
    KIND_BREAKPOINT = 3'd1,
    KIND_EMPTY      = 3'd2,
    KIND_DONE       = 3'd3,
    KIND_ACCEPTED   = 3'd4,
    KIND_RANGE_ERR  = 3'd5,
    KIND_FULL       = 3'd6
  } deq_kind_e;

  localparam logic [ModeW-1:0] BP_NONE      = 2'd0;
  localparam logic [ModeW-1:0] BP_ANY       = 2'd1;
  localparam logic [ModeW-1:0] BP_MATCH     = 2'd2;
  localparam logic [ModeW-1:0] BP_MATCH_ALT = 2'd3;

  typedef struct packed {
    deq_req_e          req;
    logic [ObjW-1:0]   obj;
    logic [TypeW-1:0]  typ;
    logic [DelayW-1:0] delay;
    logic [CountW-1:0] limit;
    logic [ModeW-1:0]  mode;
  } deq_cmd_t;

endpackage

`default_nettype wire

### src/discrete_event_queue_core.sv
// ----------------------------------------------------------------------------
// discrete_event_queue_core: time-ordered event queue with rebasing
// Schedule: a free slot is written; if the delay does not fit, a rebase first
// scans for the base and shifts every slot. Advance: a slot memory scan per result.
// Requests run one at a time; the next starts once the last result is loaded.
// Reset clears the queue, time, offset and breakpoints at once; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module discrete_event_queue_core #(
  parameter int unsigned QUEUE_DEPTH = deq_pkg::DefQueueDepth,
  parameter int unsigned NUM_OBJECTS = deq_pkg::DefNumObjects,
  parameter int unsigned TIME_BITS   = deq_pkg::DefTimeBits
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 req_type_i,
  input  wire logic [deq_pkg::ObjW-1:0]   object_id_i,
  input  wire logic [deq_pkg::TypeW-1:0]  evt_type_i,
  input  wire logic [deq_pkg::DelayW-1:0] delay_i,
  input  wire logic [deq_pkg::CountW-1:0] count_i,
  input  wire logic [deq_pkg::ModeW-1:0]  bp_mode_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [2:0]                      kind_o,
  output logic [deq_pkg::ObjW-1:0]        out_object_o,
  output logic [deq_pkg::TypeW-1:0]       out_evt_type_o,
  output logic [63:0]                     time_now_o,
  output logic                            last_o
);
  import deq_pkg::*;

  // front to back command queue
  deq_cmd_t cmd;
  logic     cmd_valid, cmd_pop;

  // Front: decode each request and hold up to two ahead of the sequencer.
  deq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .object_id_i  (object_id_i),
    .evt_type_i   (evt_type_i),
    .delay_i      (delay_i),
    .count_i      (count_i),
    .bp_mode_i    (bp_mode_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  // Back: own the slot memory, scan it for the earliest event or the rebase
  // base, and drive results through an output register so the sequencer
  // moves on while a result waits to be taken.
  deq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_OBJECTS (NUM_OBJECTS),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .out_object_o   (out_object_o),
    .out_evt_type_o (out_evt_type_o),
    .time_now_o     (time_now_o),
    .last_o         (last_o)
  );

`ifndef SYNTHESIS
  // every result other than a dispatch closes its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DISPATCHED |-> last_o)
    else $error("closing result without last");

  // a dispatch is never the closing result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DISPATCHED |-> !last_o)
    else $error("dispatch marked last");

  // schedule and set-breakpoint results carry no object or type
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_ACCEPTED || kind_o == KIND_FULL ||
                    kind_o == KIND_RANGE_ERR) |-> out_object_o == '0 && out_evt_type_o == '0)
    else $error("stray payload on status result");
`endif

endmodule

`default_nettype wire

### src/deq_front.sv
// ----------------------------------------------------------------------------
// deq_front: request intake
// Decodes each request into a command and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [1:0]               req_type_i,
  input  wire logic [deq_pkg::ObjW-1:0]   object_id_i,
  input  wire logic [deq_pkg::TypeW-1:0]  evt_type_i,
  input  wire logic [deq_pkg::DelayW-1:0] delay_i,
  input  wire logic [deq_pkg::CountW-1:0] count_i,
  input  wire logic [deq_pkg::ModeW-1:0]  bp_mode_i,
  output logic                          cmd_valid_o,
  output deq_pkg::deq_cmd_t             cmd_o,
  input  wire logic                     cmd_pop_i
);
  import deq_pkg::*;

  deq_cmd_t   entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  deq_cmd_t   cmd_in;
  logic       push;

  always_comb begin
    cmd_in.req   = deq_req_e'(req_type_i);
    cmd_in.obj   = object_id_i;
    cmd_in.typ   = evt_type_i;
    cmd_in.delay = delay_i;
    cmd_in.mode  = bp_mode_i;
    // count requests stop after count_i dispatches; others are capped at MaxDispatch
    cmd_in.limit = (cmd_in.req == REQ_ADV_COUNT) ? count_i : MaxDispatch;
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule

`default_nettype wire

### src/deq_back.sv
// ----------------------------------------------------------------------------
// deq_back: event store and sequencer
// Runs schedules, rebases and dispatches over the slot memory, one slot a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_back #(
  parameter int unsigned QUEUE_DEPTH = deq_pkg::DefQueueDepth,
  parameter int unsigned NUM_OBJECTS = deq_pkg::DefNumObjects,
  parameter int unsigned TIME_BITS   = deq_pkg::DefTimeBits
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cmd_valid_i,
  input  wire deq_pkg::deq_cmd_t         cmd_i,
  output logic                           cmd_pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [2:0]                     kind_o,
  output logic [deq_pkg::ObjW-1:0]       out_object_o,
  output logic [deq_pkg::TypeW-1:0]      out_evt_type_o,
  output logic [63:0]                    time_now_o,
  output logic                           last_o
);
  import deq_pkg::*;

  localparam int unsigned IdxW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW  = IdxW + 1;
  localparam int unsigned OidxW = $clog2(NUM_OBJECTS);
  localparam int unsigned CmpW  = (TIME_BITS > DelayW) ? TIME_BITS : DelayW;
  localparam int unsigned WordW = TIME_BITS + ObjW + TypeW + SeqW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCHED   = 4'd1;
  localparam logic [3:0] S_MINSCAN = 4'd2;
  localparam logic [3:0] S_REBASE  = 4'd3;
  localparam logic [3:0] S_WALK    = 4'd4;
  localparam logic [3:0] S_ADV     = 4'd5;
  localparam logic [3:0] S_EARLY   = 4'd6;
  localparam logic [3:0] S_PICK    = 4'd7;
  localparam logic [3:0] S_EMIT    = 4'd8;

  logic [WordW-1:0] mem [QUEUE_DEPTH];
  logic [WordW-1:0] rdata_q;
  logic [IdxW-1:0]  mem_raddr, mem_waddr;
  logic [WordW-1:0] mem_wdata;
  logic             mem_we;

  logic [3:0]            state_q, state_d;
  logic [QUEUE_DEPTH-1:0] valid_q, valid_d;
  logic [SeqW-1:0]       seq_q, seq_d;
  logic [TIME_BITS-1:0]  cur_q, cur_d;
  logic [63:0]           offset_q, offset_d;
  logic [ModeW-1:0]      bpm_q [NUM_OBJECTS];
  logic [TypeW-1:0]      bpt_q [NUM_OBJECTS];
  logic                  bp_we;

  deq_cmd_t              req_q, req_d;
  logic [CountW-1:0]     left_q, left_d;
  logic [DelayW-1:0]     budget_q, budget_d;
  logic [TIME_BITS-1:0]  base_q, base_d;

  logic [CntW-1:0]       idx_q, idx_d;
  logic                  rd_pend_q, rd_pend_d;
  logic [IdxW-1:0]       rd_addr_q, rd_addr_d;

  logic                  found_q, found_d;
  logic [TIME_BITS-1:0]  best_time_q, best_time_d;
  logic [SeqW-1:0]       best_age_q, best_age_d;
  logic [IdxW-1:0]       best_idx_q, best_idx_d;
  logic [ObjW-1:0]       best_obj_q, best_obj_d;
  logic [TypeW-1:0]      best_type_q, best_type_d;

  deq_kind_e             pend_kind_q, pend_kind_d;
  logic [ObjW-1:0]       pend_obj_q, pend_obj_d;
  logic [TypeW-1:0]      pend_type_q, pend_type_d;
  logic                  pend_last_q, pend_last_d;

  logic                  out_valid_q, out_valid_d;
  deq_kind_e             out_kind_q;
  logic [ObjW-1:0]       out_obj_q;
  logic [TypeW-1:0]      out_type_q;
  logic [63:0]           out_time_q;
  logic                  out_last_q;
  logic                  out_load, out_free;

  logic [TIME_BITS-1:0]  r_time;
  logic [ObjW-1:0]       r_obj;
  logic [TypeW-1:0]      r_type;
  logic [SeqW-1:0]       r_seq, r_age;
  logic                  slot_live, scanning, issue, scan_done;
  logic                  full;
  logic [IdxW-1:0]       free_idx;
  logic [TIME_BITS-1:0]  cost;
  logic [TIME_BITS-1:0]  headroom;
  logic [7:0]            obj_ext;
  logic [7:0]            req_obj_ext;
  logic [OidxW-1:0]      best_oidx, req_oidx;
  logic                  best_in_range, req_in_range, is_bp;

  assign r_time = rdata_q[WordW-1 -: TIME_BITS];
  assign r_obj  = rdata_q[SeqW+TypeW +: ObjW];
  assign r_type = rdata_q[SeqW +: TypeW];
  assign r_seq  = rdata_q[SeqW-1:0];
  assign r_age  = seq_q - r_seq;

  assign slot_live = rd_pend_q && valid_q[rd_addr_q];
  assign scanning  = (state_q == S_MINSCAN) || (state_q == S_WALK) || (state_q == S_EARLY);
  assign issue     = (idx_q < CntW'(QUEUE_DEPTH));
  assign scan_done = scanning && !issue && !rd_pend_q;
  assign mem_raddr = idx_q[IdxW-1:0];

  // first free slot
  always_comb begin
    full     = 1'b1;
    free_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        full     = 1'b0;
        free_idx = IdxW'(i);
      end
    end
  end

  assign cost     = best_time_q - cur_q;
  assign headroom = ~cur_q;

  // breakpoint lookup for the earliest event
  always_comb begin
    obj_ext       = 8'(best_obj_q);
    best_oidx     = obj_ext[OidxW-1:0];
    best_in_range = (9'(best_obj_q) < 9'(NUM_OBJECTS));
    if (!best_in_range || bpm_q[best_oidx] == BP_NONE) begin
      is_bp = 1'b0;
    end else if (bpm_q[best_oidx] == BP_ANY) begin
      is_bp = 1'b1;
    end else begin
      is_bp = (best_type_q == bpt_q[best_oidx]);
    end
  end

  assign req_obj_ext  = 8'(cmd_i.obj);
  assign req_oidx     = req_obj_ext[OidxW-1:0];
  assign req_in_range = (9'(cmd_i.obj) < 9'(NUM_OBJECTS));

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    seq_d       = seq_q;
    cur_d       = cur_q;
    offset_d    = offset_q;
    req_d       = req_q;
    left_d      = left_q;
    budget_d    = budget_q;
    base_d      = base_q;
    idx_d       = idx_q;
    rd_pend_d   = rd_pend_q;
    rd_addr_d   = rd_addr_q;
    found_d     = found_q;
    best_time_d = best_time_q;
    best_age_d  = best_age_q;
    best_idx_d  = best_idx_q;
    best_obj_d  = best_obj_q;
    best_type_d = best_type_q;
    pend_kind_d = pend_kind_q;
    pend_obj_d  = pend_obj_q;
    pend_type_d = pend_type_q;
    pend_last_d = pend_last_q;
    mem_we      = 1'b0;
    mem_waddr   = rd_addr_q;
    mem_wdata   = {r_time - base_q, rdata_q[WordW-TIME_BITS-1:0]};
    bp_we       = 1'b0;
    cmd_pop_o   = 1'b0;
    out_load    = 1'b0;

    if (scanning) begin
      if (issue) begin
        rd_pend_d = 1'b1;
        rd_addr_d = idx_q[IdxW-1:0];
        idx_d     = idx_q + CntW'(1);
      end else begin
        rd_pend_d = 1'b0;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          req_d     = cmd_i;
          left_d    = cmd_i.limit;
          budget_d  = cmd_i.delay;
          pend_obj_d  = '0;
          pend_type_d = '0;
          pend_last_d = 1'b1;
          unique case (cmd_i.req)
            REQ_SCHEDULE: state_d = S_SCHED;
            REQ_SET_BP: begin
              bp_we       = req_in_range;
              pend_kind_d = KIND_ACCEPTED;
              state_d     = S_EMIT;
            end
            REQ_ADV_COUNT, REQ_ADV_TIME: state_d = S_ADV;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCHED: begin
        if (full) begin
          pend_kind_d = KIND_FULL;
          state_d     = S_EMIT;
        end else if (CmpW'(headroom) < CmpW'(req_q.delay)) begin
          base_d    = cur_q;
          idx_d     = '0;
          rd_pend_d = 1'b0;
          state_d   = S_MINSCAN;
        end else begin
          mem_we          = 1'b1;
          mem_waddr       = free_idx;
          mem_wdata       = {cur_q + TIME_BITS'(req_q.delay), req_q.obj, req_q.typ, seq_q};
          valid_d[free_idx] = 1'b1;
          seq_d           = seq_q + SeqW'(1);
          pend_kind_d     = KIND_ACCEPTED;
          state_d         = S_EMIT;
        end
      end
      S_MINSCAN: begin
        if (slot_live && r_time < base_q) base_d = r_time;
        if (scan_done) state_d = S_REBASE;
      end
      S_REBASE: begin
        if (base_q == '0) begin
          pend_kind_d = KIND_RANGE_ERR;
          state_d     = S_EMIT;
        end else begin
          cur_d     = cur_q - base_q;
          offset_d  = offset_q + 64'(base_q);
          idx_d     = '0;
          rd_pend_d = 1'b0;
          state_d   = S_WALK;
        end
      end
      S_WALK: begin
        // shift every stored time down by the base
        if (slot_live) mem_we = 1'b1;
        if (scan_done) state_d = S_SCHED;
      end
      S_ADV: begin
        if (left_q == '0) begin
          pend_kind_d = KIND_DONE;
          pend_obj_d  = '0;
          pend_type_d = '0;
          pend_last_d = 1'b1;
          state_d     = S_EMIT;
        end else begin
          found_d   = 1'b0;
          idx_d     = '0;
          rd_pend_d = 1'b0;
          state_d   = S_EARLY;
        end
      end
      S_EARLY: begin
        if (slot_live && (!found_q || r_time < best_time_q ||
            (r_time == best_time_q && r_age > best_age_q))) begin
          found_d     = 1'b1;
          best_time_d = r_time;
          best_age_d  = r_age;
          best_idx_d  = rd_addr_q;
          best_obj_d  = r_obj;
          best_type_d = r_type;
        end
        if (scan_done) state_d = S_PICK;
      end
      S_PICK: begin
        state_d     = S_EMIT;
        pend_obj_d  = '0;
        pend_type_d = '0;
        pend_last_d = 1'b1;
        if (!found_q) begin
          pend_kind_d = KIND_EMPTY;
        end else if (req_q.req == REQ_ADV_TIME &&
                     CmpW'(budget_q) < CmpW'(cost)) begin
          pend_kind_d = KIND_DONE;
        end else begin
          if (req_q.req == REQ_ADV_TIME) budget_d = budget_q - DelayW'(cost);
          cur_d       = best_time_q;
          pend_obj_d  = best_obj_q;
          pend_type_d = best_type_q;
          if (is_bp) begin
            pend_kind_d = KIND_BREAKPOINT;
          end else begin
            valid_d[best_idx_q] = 1'b0;
            pend_kind_d = KIND_DISPATCHED;
            pend_last_d = 1'b0;
            left_d      = left_q - CountW'(1);
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = pend_last_q ? S_IDLE : S_ADV;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    left_q      <= left_d;
    budget_q    <= budget_d;
    base_q      <= base_d;
    rd_addr_q   <= rd_addr_d;
    found_q     <= found_d;
    best_time_q <= best_time_d;
    best_age_q  <= best_age_d;
    best_idx_q  <= best_idx_d;
    best_obj_q  <= best_obj_d;
    best_type_q <= best_type_d;
    pend_kind_q <= pend_kind_d;
    pend_obj_q  <= pend_obj_d;
    pend_type_q <= pend_type_d;
    pend_last_q <= pend_last_d;
    if (out_load) begin
      out_kind_q <= pend_kind_q;
      out_obj_q  <= pend_obj_q;
      out_type_q <= pend_type_q;
      out_time_q <= offset_q + 64'(cur_q);
      out_last_q <= pend_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      seq_q       <= '0;
      cur_q       <= '0;
      offset_q    <= '0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_OBJECTS; i++) begin
        bpm_q[i] <= '0;
        bpt_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      seq_q       <= seq_d;
      cur_q       <= cur_d;
      offset_q    <= offset_d;
      idx_q       <= idx_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      if (bp_we) begin
        bpm_q[req_oidx] <= cmd_i.mode;
        bpt_q[req_oidx] <= cmd_i.typ;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign out_object_o   = out_obj_q;
  assign out_evt_type_o = out_type_q;
  assign time_now_o     = out_time_q;
  assign last_o         = out_last_q;

endmodule

`default_nettype wire

### tb/sv/discrete_event_queue_core_checker.sv
// ----------------------------------------------------------------------------
// discrete_event_queue_core_checker: result predictor and scoreboard
// Tracks accepted request items, models the event queue state and compares
// each accepted result item field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module discrete_event_queue_core_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [1:0]                 req_type_i,
  input  logic [deq_pkg::ObjW-1:0]   object_id_i,
  input  logic [deq_pkg::TypeW-1:0]  evt_type_i,
  input  logic [deq_pkg::DelayW-1:0] delay_i,
  input  logic [deq_pkg::CountW-1:0] count_i,
  input  logic [deq_pkg::ModeW-1:0]  bp_mode_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [2:0]                 kind_i,
  input  logic [deq_pkg::ObjW-1:0]   out_object_i,
  input  logic [deq_pkg::TypeW-1:0]  out_evt_type_i,
  input  logic [63:0]                time_now_i,
  input  logic                       last_i,
  output int                         errors_o,
  output int                         pending_o,
  output int                         dispatched_o,
  output int                         rebases_o
);
  import deq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 64;
  localparam logic [31:0] TimeMax = 32'hFFFF_FFFF;

  typedef struct packed {
    deq_kind_e        kind;
    logic [ObjW-1:0]  obj;
    logic [TypeW-1:0] typ;
    logic [63:0]      now;
    logic             last;
  } result_t;

  logic [31:0]      ev_time [Depth];
  logic [ObjW-1:0]  ev_obj  [Depth];
  logic [TypeW-1:0] ev_typ  [Depth];
  logic [SeqW-1:0]  ev_seq  [Depth];
  logic             ev_live [Depth];
  logic [SeqW-1:0]  next_seq;
  logic [31:0]      now_time;
  logic [63:0]      base_offset;
  logic [ModeW-1:0] brk_mode [16];
  logic [TypeW-1:0] brk_type [16];

  result_t expected_q[$];

  function automatic int pick_earliest();
    int best;
    logic [SeqW-1:0] best_age, age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < Depth; i++) begin
      if (!ev_live[i]) continue;
      age = next_seq - ev_seq[i];
      if (best < 0 || ev_time[i] < ev_time[best] ||
          (ev_time[i] == ev_time[best] && age > best_age)) begin
        best = i;
        best_age = age;
      end
    end
    return best;
  endfunction

  function automatic void push_result(deq_kind_e k, logic [ObjW-1:0] o,
                                      logic [TypeW-1:0] t, logic l);
    result_t r;
    r.kind = k;
    r.obj  = o;
    r.typ  = t;
    r.now  = base_offset + {32'd0, now_time};
    r.last = l;
    expected_q.push_back(r);
  endfunction

  function automatic deq_kind_e schedule_event(logic [ObjW-1:0] o, logic [TypeW-1:0] t,
                                               logic [DelayW-1:0] d);
    int slot;
    logic [31:0] shift;
    slot = -1;
    for (int i = 0; i < Depth; i++)
      if (!ev_live[i]) begin
        slot = i;
        break;
      end
    if (slot < 0) return KIND_FULL;
    // Rebase until the new time fits; a zero base means no headroom is left.
    while (TimeMax - now_time < {1'b0, d}) begin
      shift = now_time;
      for (int i = 0; i < Depth; i++)
        if (ev_live[i] && ev_time[i] < shift) shift = ev_time[i];
      if (shift == 0) return KIND_RANGE_ERR;
      rebases_o++;
      now_time -= shift;
      base_offset += {32'd0, shift};
      for (int i = 0; i < Depth; i++)
        if (ev_live[i]) ev_time[i] -= shift;
    end
    ev_time[slot] = now_time + {1'b0, d};
    ev_obj[slot]  = o;
    ev_typ[slot]  = t;
    ev_seq[slot]  = next_seq;
    ev_live[slot] = 1'b1;
    next_seq++;
    return KIND_ACCEPTED;
  endfunction

  function automatic void predict_request(deq_req_e req, logic [ObjW-1:0] o,
                                          logic [TypeW-1:0] t, logic [DelayW-1:0] d,
                                          logic [CountW-1:0] n, logic [ModeW-1:0] m);
    logic [31:0] budget, cost;
    int left, s;
    bit hit;
    case (req)
      REQ_SCHEDULE: begin
        push_result(schedule_event(o, t, d), '0, '0, 1'b1);
      end
      REQ_SET_BP: begin
        brk_mode[o] = m;
        brk_type[o] = t;
        push_result(KIND_ACCEPTED, '0, '0, 1'b1);
      end
      default: begin
        budget = {1'b0, d};
        left = (req == REQ_ADV_COUNT) ? int'(n) : int'(MaxDispatch);
        forever begin
          if (left == 0) begin
            push_result(KIND_DONE, '0, '0, 1'b1);
            break;
          end
          s = pick_earliest();
          if (s < 0) begin
            push_result(KIND_EMPTY, '0, '0, 1'b1);
            break;
          end
          if (req == REQ_ADV_TIME) begin
            cost = ev_time[s] - now_time;
            if (budget < cost) begin
              push_result(KIND_DONE, '0, '0, 1'b1);
              break;
            end
            budget -= cost;
          end
          now_time = ev_time[s];
          hit = (brk_mode[ev_obj[s]] == BP_ANY) ||
                (brk_mode[ev_obj[s]][1] && ev_typ[s] == brk_type[ev_obj[s]]);
          if (hit) begin
            push_result(KIND_BREAKPOINT, ev_obj[s], ev_typ[s], 1'b1);
            break;
          end
          ev_live[s] = 1'b0;
          dispatched_o++;
          push_result(KIND_DISPATCHED, ev_obj[s], ev_typ[s], 1'b0);
          left--;
        end
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) ev_live[i] = 1'b0;
      for (int i = 0; i < 16; i++) begin
        brk_mode[i] = '0;
        brk_type[i] = '0;
      end
      next_seq = '0;
      now_time = '0;
      base_offset = '0;
      expected_q.delete();
      errors_o = 0;
      pending_o = 0;
      dispatched_o = 0;
      rebases_o = 0;
    end else begin
      // Compare the result first: a request accepted this edge cannot answer yet.
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result kind=%0d obj=%0d typ=%0d now=%0d last=%0b",
                   $time, kind_i, out_object_i, out_evt_type_i, time_now_i, last_i);
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          if (kind_i !== want.kind || out_object_i !== want.obj ||
              out_evt_type_i !== want.typ || time_now_i !== want.now ||
              last_i !== want.last) begin
            $display("%0t: mismatch expected kind=%0d obj=%0d typ=%0d now=%0d last=%0b",
                     $time, want.kind, want.obj, want.typ, want.now, want.last);
            $display("%0t:          actual   kind=%0d obj=%0d typ=%0d now=%0d last=%0b",
                     $time, kind_i, out_object_i, out_evt_type_i, time_now_i, last_i);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        predict_request(deq_req_e'(req_type_i), object_id_i, evt_type_i, delay_i,
                        count_i, bp_mode_i);
      pending_o = expected_q.size();
    end
  end
endmodule

### tb/sv/discrete_event_queue_core_tb.sv
// ----------------------------------------------------------------------------
// discrete_event_queue_core_tb: stimulus and verdict for the event queue
// Drives directed then random request items with random gaps and output
// stalls; the checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module discrete_event_queue_core_tb;
  import deq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 370;
  // Slowest case: 64 results, each after a full slot scan, plus stalls, or a long rebase.
  localparam int IdleLimit   = 20000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        req_type = '0;
  logic [ObjW-1:0]   object_id = '0;
  logic [TypeW-1:0]  evt_type = '0;
  logic [DelayW-1:0] delay = '0;
  logic [CountW-1:0] count = '0;
  logic [ModeW-1:0]  bp_mode = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        kind;
  logic [ObjW-1:0]   out_object;
  logic [TypeW-1:0]  out_evt_type;
  logic [63:0]       time_now;
  logic              last;
  int                errors, pending, dispatched, rebases;
  int                idle_cycles = 0;
  int                items_sent = 0;
  bit                stall_enable = 1'b1;

  always #4 clk = ~clk;

  discrete_event_queue_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(req_type), .object_id_i(object_id), .evt_type_i(evt_type),
    .delay_i(delay), .count_i(count), .bp_mode_i(bp_mode),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .kind_o(kind), .out_object_o(out_object), .out_evt_type_o(out_evt_type),
    .time_now_o(time_now), .last_o(last)
  );

  discrete_event_queue_core_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .req_type_i(req_type), .object_id_i(object_id), .evt_type_i(evt_type),
    .delay_i(delay), .count_i(count), .bp_mode_i(bp_mode),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .kind_i(kind), .out_object_i(out_object), .out_evt_type_i(out_evt_type),
    .time_now_i(time_now), .last_i(last),
    .errors_o(errors), .pending_o(pending),
    .dispatched_o(dispatched), .rebases_o(rebases)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Stall the result side at random; phases with stall_enable low run flat out.
  always @(posedge clk) begin
    if (!rst_n || !stall_enable) out_ready <= 1'b1;
    else out_ready <= (gap_len() == 0);
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", IdleLimit);
      $display("discrete_event_queue_core_tb NOT OK");
      $finish;
    end
  end

  // Present one request item and hold it until accepted, then drop valid
  // unless the next item follows without a gap.
  task automatic send(deq_req_e req, logic [ObjW-1:0] o, logic [TypeW-1:0] t,
                      logic [DelayW-1:0] d, logic [CountW-1:0] n, logic [ModeW-1:0] m);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= req;
    object_id <= o;
    evt_type  <= t;
    delay     <= d;
    count     <= n;
    bp_mode   <= m;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [DelayW-1:0] d;
    logic [ModeW-1:0] m;
    r = $urandom_range(0, 99);
    // Delays: mostly small, some near the top to force rebases.
    case ($urandom_range(0, 5))
      0: d = '0;
      1: d = DelayW'($urandom);
      2: d = {1'b1, 30'($urandom_range(0, 1000) + 30'h3FFF_FC00)};
      default: d = DelayW'($urandom_range(0, 200));
    endcase
    m = ModeW'($urandom_range(0, 3));
    if (r < 50)
      send(REQ_SCHEDULE, ObjW'($urandom), TypeW'($urandom_range(0, 7) |
           ($urandom_range(0, 9) == 0 ? $urandom : 0)), d, CountW'($urandom), m);
    else if (r < 72)
      send(REQ_ADV_COUNT, ObjW'($urandom), TypeW'($urandom), d,
           CountW'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 6)), m);
    else if (r < 90)
      send(REQ_ADV_TIME, ObjW'($urandom), TypeW'($urandom),
           ($urandom_range(0, 7) == 0) ? DelayW'($urandom) : DelayW'($urandom_range(0, 600)),
           CountW'($urandom), m);
    else
      // Keep breakpoints mostly off so the queue keeps draining.
      send(REQ_SET_BP, ObjW'($urandom), TypeW'($urandom_range(0, 7)), d, CountW'($urandom),
           ($urandom_range(0, 2) == 0) ? m : BP_NONE);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every request, empty queue, ties in FIFO order, breakpoints,
    // zero count, budget too short, rebase and range error.
    send(REQ_ADV_COUNT, '0, '0, '0, 6'd5, '0);
    send(REQ_ADV_TIME, '0, '0, '1, '0, '0);
    send(REQ_SCHEDULE, 4'd3, 8'd10, 31'd5, '0, '0);
    send(REQ_SCHEDULE, 4'd4, 8'd11, 31'd5, '0, '0);
    send(REQ_SCHEDULE, 4'd15, 8'hFF, 31'd0, '1, '1);
    send(REQ_ADV_COUNT, '0, '0, '0, 6'd0, '0);
    send(REQ_ADV_COUNT, '0, '0, '0, 6'd63, '0);
    send(REQ_SET_BP, 4'd7, 8'hA5, '0, '0, BP_ANY);
    send(REQ_SET_BP, 4'd8, 8'h5A, '0, '0, BP_MATCH);
    send(REQ_SET_BP, 4'd9, 8'h00, '0, '0, BP_MATCH_ALT);
    send(REQ_SCHEDULE, 4'd7, 8'd1, 31'd10, '0, '0);
    send(REQ_ADV_TIME, '0, '0, 31'd3, '0, '0);
    send(REQ_ADV_COUNT, '0, '0, '0, 6'd1, '0);
    send(REQ_SET_BP, 4'd7, 8'd0, '0, '0, BP_NONE);
    send(REQ_SCHEDULE, 4'd8, 8'h5A, 31'd2, '0, '0);
    send(REQ_SCHEDULE, 4'd8, 8'h5B, 31'd1, '0, '0);
    send(REQ_ADV_TIME, '0, '0, 31'd100, '0, '0);
    send(REQ_SET_BP, 4'd8, 8'd0, '0, '0, BP_NONE);
    send(REQ_SCHEDULE, 4'd1, 8'd2, '1, '0, '0);
    send(REQ_SCHEDULE, 4'd2, 8'd3, '1, '0, '0);
    send(REQ_SCHEDULE, 4'd2, 8'd4, '1, '0, '0);
    send(REQ_ADV_TIME, '0, '0, '1, '0, '0);
    send(REQ_ADV_COUNT, '0, '0, '0, 6'd63, '0);

    // Hold off until the queue has answered everything.
    drain();

    // Fill to capacity to reach the full answer, then empty the queue.
    stall_enable = 1'b0;
    for (int i = 0; i < 66; i++)
      send(REQ_SCHEDULE, ObjW'(i), TypeW'(i), DelayW'($urandom_range(0, 50)), '0, '0);
    send(REQ_ADV_COUNT, '0, '0, '0, 6'd63, '0);
    send(REQ_ADV_COUNT, '0, '0, '0, 6'd63, '0);
    drain();
    stall_enable = 1'b1;

    for (int i = 0; i < RandomItems; i++) begin
      random_item();
      if (i == RandomItems / 2) drain();
    end
    drain();

    $display("covered %0d request items, %0d dispatches, %0d rebases",
             items_sent, dispatched, rebases);
    if (errors == 0) begin
      $display("discrete_event_queue_core_tb OK");
    end else begin
      $display("discrete_event_queue_core_tb NOT OK");
    end
    $finish;
  end
endmodule

### sim.f
src/deq_pkg.sv
src/deq_front.sv
src/deq_back.sv
src/discrete_event_queue_core.sv
tb/sv/discrete_event_queue_core_checker.sv
tb/sv/discrete_event_queue_core_tb.sv
